[sv/gregorian_date_difference_macros.svh]
// Assertion helpers shared by the RTL. Each use names its label, the triggering
// condition, the expected condition and the message. The enclosing module must
// provide clk and rst_n.
`ifndef GREGORIAN_DATE_DIFFERENCE_MACROS_SVH
`define GREGORIAN_DATE_DIFFERENCE_MACROS_SVH

// The expected condition holds in the same cycle as the trigger.
`define GDD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The expected condition holds in the cycle after the trigger.
`define GDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/gdd_pkg.sv]
`default_nettype none

package gdd_pkg;

  localparam int MAX_YEAR_DEF = 9999;
  localparam int DAY_W        = 5;
  localparam int MONTH_W      = 4;
  localparam int YEAR_W       = 14;
  localparam int COUNT_W      = 22;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 22'd4194303;

  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

  typedef enum logic [2:0] {
    S_IDLE,
    S_YEAR,
    S_MON_B,
    S_MON_A,
    S_DAY_B,
    S_DAY_A,
    S_DONE
  } gdd_state_t;

  // Month length; month 0 and codes above 12 give 0.
  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                               input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      FEBRUARY:                                  len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
    logic [MONTH_W-1:0] r;
    r = m;
    if (m == '0) r = 4'd1;
    if (m > DECEMBER) r = DECEMBER;
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] clamp_day(input logic [DAY_W-1:0] d,
                                                 input logic [DAY_W-1:0] len);
    logic [DAY_W-1:0] r;
    r = d;
    if (d == '0) r = 5'd1;
    if (d > len) r = len;
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/gdd_in_if.sv]
`default_nettype none

interface gdd_in_if;
  logic                        valid;
  logic                        ready;
  logic [gdd_pkg::DAY_W-1:0]   start_day;
  logic [gdd_pkg::MONTH_W-1:0] start_month;
  logic [gdd_pkg::YEAR_W-1:0]  start_year;
  logic [gdd_pkg::DAY_W-1:0]   end_day;
  logic [gdd_pkg::MONTH_W-1:0] end_month;
  logic [gdd_pkg::YEAR_W-1:0]  end_year;

  modport source (output valid, start_day, start_month, start_year,
                  end_day, end_month, end_year, input ready);
  modport sink   (input valid, start_day, start_month, start_year,
                  end_day, end_month, end_year, output ready);
endinterface

`default_nettype wire

[sv/gdd_out_if.sv]
`default_nettype none

interface gdd_out_if;
  logic                        valid;
  logic                        ready;
  logic [gdd_pkg::COUNT_W-1:0] day_count;
  logic                        order_error;

  modport source (output valid, day_count, order_error, input ready);
  modport sink   (input valid, day_count, order_error, output ready);
endinterface

`default_nettype wire

[sv/gregorian_date_difference.sv]
// Days between two Gregorian dates. One request is taken at a time: the block
// walks every year from 1 up to the later of the two (clamped) years with a
// single adder, adding or subtracting 365 or 366 per year, then walks the months
// of each date and adds the day difference. The year walk dominates the time
// from acceptance to the result. The result is held until taken, and the next
// request is accepted the cycle after. Out-of-range fields are clamped to the
// nearest valid date; if the end date precedes the start date, order_error is
// set and day_count is zero. Counts above the 22-bit range saturate.
`default_nettype none

module gregorian_date_difference #(
  parameter int MAX_YEAR = gdd_pkg::MAX_YEAR_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  gdd_in_if.sink     in_req,
  gdd_out_if.source  out_res
);

  `include "gregorian_date_difference_macros.svh"

  localparam int YW    = $clog2(MAX_YEAR + 1);
  localparam int ACC_W = $clog2(MAX_YEAR * 366 + 1) + 1;

  function automatic logic [YW-1:0] clamp_year(input logic [gdd_pkg::YEAR_W-1:0] y);
    logic [YW-1:0] r;
    r = YW'(y);
    if (y == '0) r = YW'(1);
    if (32'(y) > 32'(MAX_YEAR)) r = YW'(MAX_YEAR);
    return r;
  endfunction

  gdd_pkg::gdd_state_t state_r, state_nxt;

  logic [YW-1:0]                ya_r, ya_nxt, yb_r, yb_nxt, y_r, y_nxt;
  logic [gdd_pkg::MONTH_W-1:0]  ma_r, ma_nxt, mb_r, mb_nxt, m_r, m_nxt;
  logic [gdd_pkg::DAY_W-1:0]    da_r, da_nxt, db_r, db_nxt;
  logic [6:0]                   c100_r, c100_nxt;
  logic [8:0]                   c400_r, c400_nxt;
  logic                         leap_a_r, leap_a_nxt, leap_b_r, leap_b_nxt;
  logic [ACC_W-1:0]             acc_r, acc_nxt;

  logic                         in_fire;
  logic                         leap_cur;
  logic                         year_done;
  logic                         below_a, below_b;
  logic [8:0]                   mag;
  logic                         do_add, do_sub;
  logic [ACC_W-1:0]             mag_ext;
  logic [31:0]                  acc_ext;

  assign in_fire   = in_req.valid && in_req.ready;
  // Year modulo 4 is its low two bits; modulo 100 and 400 are kept as counters.
  assign leap_cur  = (c400_r == '0) || ((y_r[1:0] == 2'b00) && (c100_r != '0));
  assign year_done = (y_r >= ya_r) && (y_r >= yb_r);
  assign below_a   = y_r < ya_r;
  assign below_b   = y_r < yb_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gdd_pkg::S_IDLE:  if (in_fire) state_nxt = gdd_pkg::S_YEAR;
      gdd_pkg::S_YEAR:  if (year_done) state_nxt = gdd_pkg::S_MON_B;
      gdd_pkg::S_MON_B: if (m_r >= mb_r) state_nxt = gdd_pkg::S_MON_A;
      gdd_pkg::S_MON_A: if (m_r >= ma_r) state_nxt = gdd_pkg::S_DAY_B;
      gdd_pkg::S_DAY_B: state_nxt = gdd_pkg::S_DAY_A;
      gdd_pkg::S_DAY_A: state_nxt = gdd_pkg::S_DONE;
      gdd_pkg::S_DONE:  if (out_res.ready) state_nxt = gdd_pkg::S_IDLE;
      default:          state_nxt = gdd_pkg::S_IDLE;
    endcase
  end

  // Datapath control and the shared accumulator adder.
  always_comb begin
    ya_nxt     = ya_r;
    yb_nxt     = yb_r;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    da_nxt     = da_r;
    db_nxt     = db_r;
    y_nxt      = y_r;
    m_nxt      = m_r;
    c100_nxt   = c100_r;
    c400_nxt   = c400_r;
    leap_a_nxt = leap_a_r;
    leap_b_nxt = leap_b_r;
    mag        = '0;
    do_add     = 1'b0;
    do_sub     = 1'b0;
    case (state_r)
      gdd_pkg::S_IDLE: begin
        ya_nxt   = clamp_year(in_req.start_year);
        yb_nxt   = clamp_year(in_req.end_year);
        ma_nxt   = gdd_pkg::clamp_month(in_req.start_month);
        mb_nxt   = gdd_pkg::clamp_month(in_req.end_month);
        da_nxt   = in_req.start_day;
        db_nxt   = in_req.end_day;
        y_nxt    = YW'(1);
        c100_nxt = 7'd1;
        c400_nxt = 9'd1;
      end
      gdd_pkg::S_YEAR: begin
        if (y_r == ya_r) leap_a_nxt = leap_cur;
        if (y_r == yb_r) leap_b_nxt = leap_cur;
        mag    = leap_cur ? 9'd366 : 9'd365;
        do_add = below_b && !below_a;
        do_sub = below_a && !below_b;
        if (year_done) begin
          m_nxt = 4'd1;
        end else begin
          y_nxt    = y_r + YW'(1);
          c100_nxt = (c100_r == 7'd99) ? 7'd0 : c100_r + 7'd1;
          c400_nxt = (c400_r == 9'd399) ? 9'd0 : c400_r + 9'd1;
        end
      end
      gdd_pkg::S_MON_B: begin
        mag = 9'(gdd_pkg::days_in(m_r, leap_b_r));
        if (m_r < mb_r) begin
          do_add = 1'b1;
          m_nxt  = m_r + 4'd1;
        end else begin
          m_nxt = 4'd1;
        end
      end
      gdd_pkg::S_MON_A: begin
        mag = 9'(gdd_pkg::days_in(m_r, leap_a_r));
        if (m_r < ma_r) begin
          do_sub = 1'b1;
          m_nxt  = m_r + 4'd1;
        end
      end
      gdd_pkg::S_DAY_B: begin
        mag    = 9'(gdd_pkg::clamp_day(db_r, gdd_pkg::days_in(mb_r, leap_b_r)));
        do_add = 1'b1;
      end
      gdd_pkg::S_DAY_A: begin
        mag    = 9'(gdd_pkg::clamp_day(da_r, gdd_pkg::days_in(ma_r, leap_a_r)));
        do_sub = 1'b1;
      end
      default: begin
      end
    endcase

    mag_ext = ACC_W'(mag);
    acc_nxt = acc_r;
    if (state_r == gdd_pkg::S_IDLE) acc_nxt = '0;
    else if (do_add) acc_nxt = acc_r + mag_ext;
    else if (do_sub) acc_nxt = acc_r - mag_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gdd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    ya_r     <= ya_nxt;
    yb_r     <= yb_nxt;
    ma_r     <= ma_nxt;
    mb_r     <= mb_nxt;
    da_r     <= da_nxt;
    db_r     <= db_nxt;
    y_r      <= y_nxt;
    m_r      <= m_nxt;
    c100_r   <= c100_nxt;
    c400_r   <= c400_nxt;
    leap_a_r <= leap_a_nxt;
    leap_b_r <= leap_b_nxt;
    acc_r    <= acc_nxt;
  end

  // A negative difference means the end date came first.
  assign acc_ext = 32'(acc_r);

  always_comb begin
    in_req.ready        = (state_r == gdd_pkg::S_IDLE);
    out_res.valid       = (state_r == gdd_pkg::S_DONE);
    out_res.order_error = acc_r[ACC_W-1];
    if (acc_r[ACC_W-1]) begin
      out_res.day_count = '0;
    end else if (acc_ext > 32'(gdd_pkg::COUNT_MAX)) begin
      out_res.day_count = gdd_pkg::COUNT_MAX;
    end else begin
      out_res.day_count = gdd_pkg::COUNT_W'(acc_ext);
    end
  end

  `GDD_ASSERT_NEXT(a_start_walk, in_fire,
    (state_r == gdd_pkg::S_YEAR) && (y_r == YW'(1)),
    "year walk did not start at year one")
  `GDD_ASSERT_SAME(a_year_bound, state_r == gdd_pkg::S_YEAR,
    (y_r <= ya_r) || (y_r <= yb_r), "year walk ran past the later year")
  `GDD_ASSERT_SAME(a_month_bound,
    (state_r == gdd_pkg::S_MON_B) || (state_r == gdd_pkg::S_MON_A),
    m_r <= gdd_pkg::DECEMBER, "month walk ran past December")
  `GDD_ASSERT_SAME(a_error_zero, out_res.valid && out_res.order_error,
    out_res.day_count == '0, "order error with nonzero day count")

endmodule

`default_nettype wire
